// ===== rtl/core/qfr_pkg.sv =====
// qfr_pkg: shared constants, control word types and microprogram for the quadratic form rate block
package qfr_pkg;

   // matrix size limit and derived widths
   localparam int MAX_DIM   = 16;
   localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W     = $clog2(MAX_DIM + 1);
   localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
   localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

   // fixed field widths
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int DIM_W  = 5;
   localparam int POS_W  = 4;
   localparam int ACC_W  = 64;
   localparam int MUL_W  = DATA_W + 1;
   localparam int PROD_W = 96;
   localparam int TQ_W   = PROD_W - FRAC_W;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

   typedef enum logic {
      REG_DIM,
      REG_ALPHA
   } reg_idx_type;

   // item commands
   localparam logic CMD_ENTRY = 1'b0;
   localparam logic CMD_ELEM  = 1'b1;

   // saturation limits
   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // multiplier operand selection and destination
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_P_VEC,
      MUL_P_SELF,
      MUL_LO_S,
      MUL_HI_S,
      MUL_LO_M,
      MUL_HI_M
   } mul_sel_type;

   // memory read issue
   typedef enum logic [1:0] {
      RD_NONE,
      RD_KJ,
      RD_JK
   } rd_sel_type;

   // sequencer jump kinds
   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_WAIT,
      JMP_LOOP,
      JMP_ELEM,
      JMP_EMIT
   } jmp_type;

   // microprogram steps
   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_L1,
      STEP_L2,
      STEP_L3,
      STEP_L4,
      STEP_L5,
      STEP_L6,
      STEP_L7,
      STEP_L8,
      STEP_D1,
      STEP_D2,
      STEP_D3,
      STEP_D4,
      STEP_D5,
      STEP_D6,
      STEP_OUT
   } step_type;

   typedef struct packed {
      mul_sel_type mul;
      logic        ld_s;
      rd_sel_type  rd;
      logic        comb;
      logic        trunc;
      logic        acc;
      logic        inc_j;
      jmp_type     jmp;
   } uword_type;

   typedef struct packed {
      logic start;
      logic k_zero;
      logic j_lt_k;
      logic elem_last;
   } status_type;

   // control store: one word per step
   function automatic uword_type ucode(step_type s);
      uword_type w;
      w = '{mul: MUL_NONE, ld_s: 1'b0, rd: RD_NONE, comb: 1'b0, trunc: 1'b0,
            acc: 1'b0, inc_j: 1'b0, jmp: JMP_NEXT};
      case (s)
         STEP_IDLE: begin
            w.rd  = RD_KJ;
            w.jmp = JMP_WAIT;
         end
         STEP_L1: begin
            w.mul  = MUL_P_VEC;
            w.ld_s = 1'b1;
            w.rd   = RD_JK;
         end
         STEP_L2: w.mul = MUL_LO_S;
         STEP_L3: w.mul = MUL_HI_S;
         STEP_L4: begin
            w.comb = 1'b1;
            w.mul  = MUL_LO_M;
         end
         STEP_L5: begin
            w.trunc = 1'b1;
            w.mul   = MUL_HI_M;
         end
         STEP_L6: begin
            w.acc   = 1'b1;
            w.comb  = 1'b1;
            w.inc_j = 1'b1;
         end
         STEP_L7: begin
            w.trunc = 1'b1;
            w.rd    = RD_KJ;
         end
         STEP_L8: begin
            w.acc = 1'b1;
            w.jmp = JMP_LOOP;
         end
         STEP_D1: begin
            w.mul  = MUL_P_SELF;
            w.ld_s = 1'b1;
         end
         STEP_D2: w.mul = MUL_LO_S;
         STEP_D3: w.mul = MUL_HI_S;
         STEP_D4: w.comb = 1'b1;
         STEP_D5: w.trunc = 1'b1;
         STEP_D6: begin
            w.acc = 1'b1;
            w.jmp = JMP_ELEM;
         end
         STEP_OUT: w.jmp = JMP_EMIT;
         default: w.jmp = JMP_WAIT;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/qfr_req_if.sv =====
// qfr_req_if: input channel carrying matrix entry writes and vector elements
interface qfr_req_if;
   import qfr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [POS_W-1:0]         row;
   logic [POS_W-1:0]         col;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output cmd, output row, output col, output value,
                   input ready);
   modport sink   (input valid, input cmd, input row, input col, input value,
                   output ready);
endinterface

// ===== rtl/core/qfr_rsp_if.sv =====
// qfr_rsp_if: result channel carrying the rate and the saturation flag
interface qfr_rsp_if;
   import qfr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ACC_W-1:0] rate;
   logic                    saturated;

   modport source (output valid, output rate, output saturated, input ready);
   modport sink   (input valid, input rate, input saturated, output ready);
endinterface

// ===== rtl/core/qfr_ram.sv =====
// qfr_ram: generic single write port, single read port ram with registered read data
module qfr_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/qfr_seq.sv =====
// qfr_seq: step counter, control store lookup and conditional jumps
module qfr_seq (
   input  logic                clock,
   input  logic                reset,
   input  qfr_pkg::status_type stat,
   input  logic                out_free,
   output qfr_pkg::uword_type  ctl
);
   import qfr_pkg::*;

   step_type  upc_ff;
   step_type  upc_in;
   uword_type word;

   // control word for the current step
   assign word = ucode(upc_ff);
   assign ctl  = word;

   // next step
   always_comb begin
      case (word.jmp)
         JMP_NEXT: upc_in = step_type'(upc_ff + 4'd1);
         JMP_WAIT: begin
            if (stat.start) begin
               upc_in = stat.k_zero ? STEP_D1 : STEP_L1;
            end else begin
               upc_in = STEP_IDLE;
            end
         end
         JMP_LOOP: upc_in = stat.j_lt_k ? STEP_L1 : STEP_D1;
         JMP_ELEM: upc_in = stat.elem_last ? STEP_OUT : STEP_IDLE;
         JMP_EMIT: upc_in = out_free ? STEP_IDLE : STEP_OUT;
         default:  upc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end
endmodule

// ===== rtl/core/qfr_dp.sv =====
// qfr_dp: matrix and vector stores, shared multiplier, term rounding and saturating accumulator
module qfr_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  qfr_pkg::uword_type           ctl,
   input  logic                         req_fire,
   input  logic                         req_cmd,
   input  logic [qfr_pkg::POS_W-1:0]    req_row,
   input  logic [qfr_pkg::POS_W-1:0]    req_col,
   input  logic [qfr_pkg::DATA_W-1:0]   req_value,
   input  logic [qfr_pkg::DIM_W-1:0]    dim,
   input  logic [qfr_pkg::DATA_W-1:0]   alpha,
   input  logic                         emit,
   output qfr_pkg::status_type          stat,
   output logic [qfr_pkg::ACC_W-1:0]    rate,
   output logic                         saturated
);
   import qfr_pkg::*;

   // registers
   logic [DATA_W-1:0] x_ff,     x_in;
   logic [DATA_W-1:0] s_ff,     s_in;
   logic [ACC_W-1:0]  p_ff,     p_in;
   logic [ACC_W-1:0]  lo_ff,    lo_in;
   logic [ACC_W-1:0]  hi_ff,    hi_in;
   logic [PROD_W-1:0] prod_ff,  prod_in;
   logic [ACC_W-1:0]  term_ff,  term_in;
   logic [ACC_W-1:0]  sum_ff,   sum_in;
   logic              ovf_ff,   ovf_in;
   logic [IDX_W-1:0]  j_ff,     j_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // memories
   logic              mat_we;
   logic [MAT_AW-1:0] mat_wr_addr;
   logic [MAT_AW-1:0] mat_rd_addr;
   logic [DATA_W-1:0] mat_rd;
   logic              vec_we;
   logic [DATA_W-1:0] vec_rd;
   logic              rd_en;

   // element position and dimension
   logic [IDX_W-1:0]  k;
   logic [CNT_W-1:0]  dim_eff;
   logic [CNT_W-1:0]  count_next;
   logic              start;

   // multiplier
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic signed [2*MUL_W-1:0] mul_full;
   logic [ACC_W-1:0]          mul_res;

   // rounding and accumulation
   logic [TQ_W-1:0]   shr;
   logic [TQ_W-1:0]   q;
   logic              adj;
   logic              q_fits;
   logic [ACC_W-1:0]  acc_sum;
   logic              acc_ovf;

   assign start = req_fire && (req_cmd == CMD_ELEM);

   // current element index, clamped to the last row
   always_comb begin
      if (32'(count_ff) >= MAX_DIM) begin
         k = IDX_W'(MAX_DIM - 1);
      end else begin
         k = count_ff[IDX_W-1:0];
      end
      if (dim == '0) begin
         dim_eff = CNT_W'(1);
      end else if (32'(dim) > MAX_DIM) begin
         dim_eff = CNT_W'(MAX_DIM);
      end else begin
         dim_eff = CNT_W'(dim);
      end
      count_next = CNT_W'(k) + CNT_W'(1);
   end

   assign stat.start     = start;
   assign stat.k_zero    = (k == '0);
   assign stat.j_lt_k    = (j_ff < k);
   assign stat.elem_last = (count_next >= dim_eff);

   // matrix store: entry writes straight from the input, reads under microcode
   assign mat_we      = req_fire && (req_cmd == CMD_ENTRY)
                        && (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
   assign mat_wr_addr = MAT_AW'(req_row) * MAT_AW'(MAX_DIM) + MAT_AW'(req_col);
   assign rd_en       = (ctl.rd != RD_NONE);

   always_comb begin
      if (ctl.rd == RD_JK) begin
         mat_rd_addr = MAT_AW'(j_ff) * MAT_AW'(MAX_DIM) + MAT_AW'(k);
      end else begin
         mat_rd_addr = MAT_AW'(k) * MAT_AW'(MAX_DIM) + MAT_AW'(j_ff);
      end
   end

   qfr_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_mat (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (mat_rd_addr),
      .rd_data (mat_rd)
   );

   // vector store: element written once its terms are in the sum
   assign vec_we = (ctl.jmp == JMP_ELEM);

   qfr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_vec (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (k),
      .wr_data (x_ff),
      .rd_en   (rd_en),
      .rd_addr (j_ff),
      .rd_data (vec_rd)
   );

   // shared signed multiplier operand select
   always_comb begin
      case (ctl.mul)
         MUL_P_VEC: begin
            mul_a = {x_ff[DATA_W-1], x_ff};
            mul_b = {vec_rd[DATA_W-1], vec_rd};
         end
         MUL_P_SELF: begin
            mul_a = {x_ff[DATA_W-1], x_ff};
            mul_b = {x_ff[DATA_W-1], x_ff};
         end
         MUL_LO_S: begin
            mul_a = {1'b0, p_ff[DATA_W-1:0]};
            mul_b = {s_ff[DATA_W-1], s_ff};
         end
         MUL_HI_S: begin
            mul_a = {p_ff[ACC_W-1], p_ff[ACC_W-1:DATA_W]};
            mul_b = {s_ff[DATA_W-1], s_ff};
         end
         MUL_LO_M: begin
            mul_a = {1'b0, p_ff[DATA_W-1:0]};
            mul_b = {mat_rd[DATA_W-1], mat_rd};
         end
         MUL_HI_M: begin
            mul_a = {p_ff[ACC_W-1], p_ff[ACC_W-1:DATA_W]};
            mul_b = {mat_rd[DATA_W-1], mat_rd};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign mul_res  = mul_full[ACC_W-1:0];

   // product registers
   always_comb begin
      p_in  = p_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      case (ctl.mul)
         MUL_P_VEC, MUL_P_SELF: p_in  = mul_res;
         MUL_LO_S,  MUL_LO_M:   lo_in = mul_res;
         MUL_HI_S,  MUL_HI_M:   hi_in = mul_res;
         default: begin
            p_in = p_ff;
         end
      endcase
   end

   assign s_in = ctl.ld_s ? mat_rd : s_ff;
   assign x_in = start ? req_value : x_ff;

   // full 96-bit product from the two partial products
   assign prod_in = ctl.comb ? ({hi_ff, {DATA_W{1'b0}}}
                                + {{(PROD_W-ACC_W){lo_ff[ACC_W-1]}}, lo_ff})
                             : prod_ff;

   // drop the fraction toward zero, then clamp to 64 bits
   always_comb begin
      shr    = prod_ff[PROD_W-1:FRAC_W];
      adj    = prod_ff[PROD_W-1] && (prod_ff[FRAC_W-1:0] != '0);
      q      = shr + TQ_W'(adj);
      q_fits = (q[TQ_W-1:ACC_W-1] == '0) || (q[TQ_W-1:ACC_W-1] == '1);
      if (!ctl.trunc) begin
         term_in = term_ff;
      end else if (q_fits) begin
         term_in = q[ACC_W-1:0];
      end else begin
         term_in = q[TQ_W-1] ? ACC_MIN : ACC_MAX;
      end
   end

   // saturating accumulate
   always_comb begin
      acc_sum = sum_ff + term_ff;
      acc_ovf = (sum_ff[ACC_W-1] == term_ff[ACC_W-1])
                && (acc_sum[ACC_W-1] != sum_ff[ACC_W-1]);
      if (emit) begin
         sum_in = '0;
      end else if (!ctl.acc) begin
         sum_in = sum_ff;
      end else if (acc_ovf) begin
         sum_in = sum_ff[ACC_W-1] ? ACC_MIN : ACC_MAX;
      end else begin
         sum_in = acc_sum;
      end
   end

   // sticky saturation flag for the vector
   always_comb begin
      if (emit) begin
         ovf_in = 1'b0;
      end else begin
         ovf_in = ovf_ff || (ctl.trunc && !q_fits) || (ctl.acc && acc_ovf);
      end
   end

   // loop index and element count
   always_comb begin
      if (start || (ctl.jmp == JMP_ELEM)) begin
         j_in = '0;
      end else if (ctl.inc_j) begin
         j_in = j_ff + IDX_W'(1);
      end else begin
         j_in = j_ff;
      end
      if (emit) begin
         count_in = '0;
      end else if (ctl.jmp == JMP_ELEM) begin
         count_in = count_next;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         j_ff     <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         j_ff     <= j_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      s_ff    <= s_in;
      p_ff    <= p_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      prod_ff <= prod_in;
      term_ff <= term_in;
   end

   // halve the sum (flooring) and add half the offset, which is exact since the offset is even
   assign rate = {sum_ff[ACC_W-1], sum_ff[ACC_W-1:1]}
                 + {{(ACC_W-DATA_W-FRAC_W+1){alpha[DATA_W-1]}}, alpha,
                    {(FRAC_W-1){1'b0}}};
   assign saturated = ovf_ff;
endmodule

// ===== rtl/core/quadratic_form_rate.sv =====
// quadratic_form_rate: streaming (x^T S x + offset) / 2, microcoded multiply/accumulate
// matrix entry writes: one transfer per cycle while the sequencer is idle, no result
// vector element k (from 0): input held off from its transfer until its program ends; each earlier element
//   costs 8 steps of the one shared 33x33 multiplier loop, the diagonal term 6 more
// last element: result registered at the output step, which waits while the result register is full
// reset: synchronous; clears sequencer, count, sum, flag, result valid; matrix/vector not cleared
module quadratic_form_rate (
   input  logic                          clock,
   input  logic                          reset,
   qfr_req_if.sink                       req_bus,
   qfr_rsp_if.source                     rsp_bus,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [qfr_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [qfr_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [qfr_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import qfr_pkg::*;

   // configuration registers
   logic [DIM_W-1:0]  dim_ff,   dim_in;
   logic [DATA_W-1:0] ofs_ff,   ofs_in;
   logic              csr_wr;
   reg_idx_type       csr_idx;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]  rate_ff,      rate_in;
   logic              sat_ff,       sat_in;

   // sequencer and datapath
   uword_type         ctl;
   status_type        stat;
   logic              req_fire;
   logic              out_free;
   logic              emit;
   logic [ACC_W-1:0]  dp_rate;
   logic              dp_sat;

   // configuration writes and reads
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_AW-1:2]);

   always_comb begin
      dim_in = dim_ff;
      ofs_in = ofs_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_DIM:   dim_in = csr_pwdata[DIM_W-1:0];
            REG_ALPHA: ofs_in = csr_pwdata[DATA_W-1:0];
            default:   dim_in = dim_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DIM:   csr_prdata = CSR_DW'(dim_ff);
         REG_ALPHA: csr_prdata = CSR_DW'(ofs_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // input transfers only while the sequencer waits at its idle step
   assign req_bus.ready = (ctl.jmp == JMP_WAIT);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // result register frees up when empty or being taken
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit     = (ctl.jmp == JMP_EMIT) && out_free;

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rate_in = emit ? dp_rate : rate_ff;
      sat_in  = emit ? dp_sat  : sat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= DIM_RESET;
         ofs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dim_ff       <= dim_in;
         ofs_ff       <= ofs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff <= rate_in;
      sat_ff  <= sat_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.rate      = rate_ff;
   assign rsp_bus.saturated = sat_ff;

   qfr_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .stat     (stat),
      .out_free (out_free),
      .ctl      (ctl)
   );

   qfr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_fire  (req_fire),
      .req_cmd   (req_bus.cmd),
      .req_row   (req_bus.row),
      .req_col   (req_bus.col),
      .req_value (req_bus.value),
      .dim       (dim_ff),
      .alpha     (ofs_ff),
      .emit      (emit),
      .stat      (stat),
      .rate      (dp_rate),
      .saturated (dp_sat)
   );

   // an element transfer starts the program, so input closes on the next cycle
   a_elem_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_bus.cmd == CMD_ELEM)) |=> !req_bus.ready)
      else $error("input still open after a vector element transfer");

   // an entry write leaves the sequencer idle
   a_entry_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_bus.cmd == CMD_ENTRY)) |=> req_bus.ready)
      else $error("entry write disturbed the sequencer");

   // a new result only comes from the emit step
   a_emit_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.jmp == JMP_EMIT))
      else $error("result loaded outside the emit step");

   // a finished vector waits at the emit step while the result register is full
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      ((ctl.jmp == JMP_EMIT) && !out_free) |=> (ctl.jmp == JMP_EMIT))
      else $error("finished vector left the emit step while the result was held");
endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for quadratic_form_rate with a bit-exact rate predictor
`timescale 1ns / 100ps

module tb;
   import qfr_pkg::*;

   localparam int  SETTLE      = 160;
   localparam int  CYCLE_LIMIT = 1500000;
   localparam int  PHASES      = 24;

   typedef struct packed {
      logic              cmd;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [DATA_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [ACC_W-1:0] rate;
      logic             sat;
   } rate_result_type;

   typedef struct packed {
      logic            is_cfg;
      reg_idx_type     reg_sel;
      logic [31:0]     data;
      req_item_type    item;
      logic            typed;
      rate_result_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   qfr_req_if req_if ();
   qfr_rsp_if rsp_if ();

   quadratic_form_rate u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   always #6 clock = ~clock;

   // predictor state and configuration copy
   logic [DATA_W-1:0] s_mat [MAX_DIM][MAX_DIM];
   logic [DATA_W-1:0] x_buf [MAX_DIM];
   int                x_count;
   logic [ACC_W-1:0]  form_sum;
   logic              form_ovf;
   logic [DIM_W-1:0]  dim_cfg;
   logic [DATA_W-1:0] alpha_cfg;
   logic              term_sat;

   rate_result_type pending_rates [$];
   int              fail_count  = 0;
   int              send_idle;
   int              recv_idle;
   int              cycle_count = 0;

   // one term (s * xi * xj) >> 16 toward zero, clamped to 64 bits
   function automatic logic [ACC_W-1:0] quad_term(logic [31:0] s, logic [31:0] xi,
                                                  logic [31:0] xj);
      logic signed [127:0] a, b, c, prod, mag;
      logic [ACC_W-1:0]    res;
      a    = $signed(xi);
      b    = $signed(xj);
      c    = $signed(s);
      prod = a * b * c;
      mag  = (prod < 0) ? -prod : prod;
      mag  = mag >> 16;
      if (prod < 0) begin
         if (mag > 128'sh8000_0000_0000_0000) begin
            term_sat = 1'b1;
            res      = ACC_MIN;
         end else begin
            res = -mag[63:0];
         end
      end else if (mag > 128'sh7FFF_FFFF_FFFF_FFFF) begin
         term_sat = 1'b1;
         res      = ACC_MAX;
      end else begin
         res = mag[63:0];
      end
      return res;
   endfunction

   // signed add clamped to 64 bits
   function automatic logic [ACC_W-1:0] sum_clamp(logic signed [63:0] x,
                                                  logic signed [63:0] y);
      logic signed [64:0] r;
      r = x + y;
      if (r[64] != r[63]) begin
         term_sat = 1'b1;
         return r[64] ? ACC_MIN : ACC_MAX;
      end
      return r[63:0];
   endfunction

   // apply one accepted item and queue the rate it produces, if any
   task automatic compute_rate_item(req_item_type it, logic typed, rate_result_type want);
      int                 eff_dim;
      int                 k;
      logic signed [63:0] aq;
      logic signed [65:0] total;
      rate_result_type    res;
      if (it.cmd == CMD_ENTRY) begin
         s_mat[it.row][it.col] = it.value;
      end else begin
         eff_dim  = (dim_cfg == 0) ? 1 : (dim_cfg > MAX_DIM) ? MAX_DIM : int'(dim_cfg);
         k        = (x_count >= MAX_DIM) ? MAX_DIM - 1 : x_count;
         term_sat = 1'b0;
         x_buf[k] = it.value;
         for (int j = 0; j < k; j++) begin
            form_sum = sum_clamp(form_sum, quad_term(s_mat[k][j], it.value, x_buf[j]));
            form_sum = sum_clamp(form_sum, quad_term(s_mat[j][k], x_buf[j], it.value));
         end
         form_sum = sum_clamp(form_sum, quad_term(s_mat[k][k], it.value, it.value));
         form_ovf = form_ovf | term_sat;
         x_count  = k + 1;
         if (x_count >= eff_dim) begin
            aq       = {{16{alpha_cfg[31]}}, alpha_cfg, 16'h0000};
            total    = $signed(form_sum) + aq;
            res.rate = total[64:1];
            res.sat  = form_ovf;
            pending_rates.push_back(typed ? want : res);
            x_count  = 0;
            form_sum = '0;
            form_ovf = 1'b0;
         end
      end
   endtask

   // send one item with a random lead-in gap, predict at the transfer edge
   task automatic push_item(req_item_type it, logic typed, rate_result_type want);
      if ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd   <= it.cmd;
      req_if.row   <= it.row;
      req_if.col   <= it.col;
      req_if.value <= it.value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      compute_rate_item(it, typed, want);
   endtask

   // wait for every queued rate to arrive
   task automatic drain_rates();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_rates.size() != 0) @(posedge clock);
   endtask

   // register write while the block is idle
   task automatic write_reg(reg_idx_type idx, logic [31:0] data);
      drain_rates();
      repeat (SETTLE) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(int'(idx) * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_DIM:   dim_cfg   = data[DIM_W-1:0];
         REG_ALPHA: alpha_cfg = data;
         default: ;
      endcase
   endtask

   // random Q16.16 value, mostly moderate magnitudes
   function automatic logic [31:0] rand_q16();
      logic signed [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         0: return r;
         1: begin
            case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return r >>> $urandom_range(8, 24);
      endcase
   endfunction

   function automatic plan_row_type cfg_row(reg_idx_type idx, logic [31:0] data);
      plan_row_type p;
      p         = '0;
      p.is_cfg  = 1'b1;
      p.reg_sel = idx;
      p.data    = data;
      return p;
   endfunction

   function automatic plan_row_type item_row(logic cmd, logic [3:0] r, logic [3:0] c,
                                             logic [31:0] v);
      plan_row_type p;
      p            = '0;
      p.item.cmd   = cmd;
      p.item.row   = r;
      p.item.col   = c;
      p.item.value = v;
      return p;
   endfunction

   function automatic plan_row_type known_row(logic [31:0] v, logic [63:0] rate, logic sat);
      plan_row_type p;
      p           = item_row(CMD_ELEM, 4'h0, 4'h0, v);
      p.typed     = 1'b1;
      p.want.rate = rate;
      p.want.sat  = sat;
      return p;
   endfunction

   // result side: check each transfer, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_rates.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected rate transfer: rate=%h sat=%b",
                           rsp_if.rate, rsp_if.saturated);
            end else begin
               rate_result_type exp_r;
               exp_r = pending_rates.pop_front();
               if (rsp_if.rate !== exp_r.rate || rsp_if.saturated !== exp_r.sat) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("rate mismatch: expected rate=%h sat=%b, got rate=%h sat=%b",
                              exp_r.rate, exp_r.sat, rsp_if.rate, rsp_if.saturated);
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // stimulus
   initial begin
      plan_row_type plan [$];
      req_item_type it;
      int           n;
      logic [31:0]  alpha_pick;
      logic [4:0]   dim_pick;

      // inputs known from time zero
      req_if.valid = 1'b0;
      req_if.cmd   = CMD_ENTRY;
      req_if.row   = '0;
      req_if.col   = '0;
      req_if.value = '0;

      x_count     = 0;
      form_sum    = '0;
      form_ovf    = 1'b0;
      dim_cfg     = DIM_RESET;
      alpha_cfg   = '0;
      send_idle   = 17;
      recv_idle   = 70;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: dimension one with extreme entries and elements
      plan.push_back(cfg_row(REG_DIM, 32'd0));
      plan.push_back(cfg_row(REG_ALPHA, 32'h0000_0000));
      plan.push_back(item_row(CMD_ENTRY, 4'd0, 4'd0, 32'h0001_0000));
      plan.push_back(known_row(32'h0001_0000, 64'h0000_0000_8000_0000, 1'b0));
      plan.push_back(known_row(32'h0000_0000, 64'h0000_0000_0000_0000, 1'b0));
      // negative term: truncation toward zero, then floor on halving
      plan.push_back(item_row(CMD_ENTRY, 4'd0, 4'd0, 32'hFFFF_FFFF));
      plan.push_back(known_row(32'h0000_0100, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
      plan.push_back(known_row(32'h0000_0001, 64'h0000_0000_0000_0000, 1'b0));
      // term saturation both ways
      plan.push_back(item_row(CMD_ENTRY, 4'd0, 4'd0, 32'h8000_0000));
      plan.push_back(known_row(32'h8000_0000, 64'hC000_0000_0000_0000, 1'b1));
      plan.push_back(item_row(CMD_ENTRY, 4'd0, 4'd0, 32'h7FFF_FFFF));
      plan.push_back(known_row(32'h8000_0000, 64'h3FFF_FFFF_FFFF_FFFF, 1'b1));
      // offset extremes
      plan.push_back(cfg_row(REG_ALPHA, 32'h7FFF_FFFF));
      plan.push_back(item_row(CMD_ELEM, 4'd0, 4'd0, 32'h7FFF_FFFF));
      plan.push_back(cfg_row(REG_ALPHA, 32'h8000_0000));
      plan.push_back(known_row(32'h0000_0000, 64'hFFFF_C000_0000_0000, 1'b0));
      plan.push_back(item_row(CMD_ELEM, 4'hF, 4'hF, 32'h0001_0000));
      // dimension two with cross terms
      plan.push_back(cfg_row(REG_DIM, 32'd2));
      plan.push_back(item_row(CMD_ENTRY, 4'd0, 4'd1, 32'h0002_0000));
      plan.push_back(item_row(CMD_ENTRY, 4'd1, 4'd0, 32'hFFFE_8000));
      plan.push_back(item_row(CMD_ENTRY, 4'd1, 4'd1, 32'h0003_0000));
      plan.push_back(item_row(CMD_ELEM, 4'd0, 4'd0, 32'h0001_8000));
      plan.push_back(item_row(CMD_ELEM, 4'd0, 4'd0, 32'hFFFF_0000));
      // dimension lowered in the middle of a vector
      plan.push_back(item_row(CMD_ELEM, 4'd0, 4'd0, 32'h0005_0000));
      plan.push_back(cfg_row(REG_DIM, 32'd1));
      plan.push_back(item_row(CMD_ELEM, 4'd0, 4'd0, 32'h1234_5678));

      foreach (plan[i]) begin
         if (plan[i].is_cfg)
            write_reg(plan[i].reg_sel, plan[i].data);
         else
            push_item(plan[i].item, plan[i].typed, plan[i].want);
      end

      // fill the whole matrix before any wider vector reads it
      for (int r = 0; r < MAX_DIM; r++) begin
         for (int c = 0; c < MAX_DIM; c++) begin
            it = '{cmd: CMD_ENTRY, row: POS_W'(r), col: POS_W'(c), value: rand_q16()};
            push_item(it, 1'b0, '0);
         end
      end

      // random phases: sender light / receiver heavy, swapped, then no idling
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph / (PHASES / 3))
            0:       begin send_idle = 17; recv_idle = 70; end
            1:       begin send_idle = 70; recv_idle = 17; end
            default: begin send_idle = 0;  recv_idle = 0;  end
         endcase
         case (ph % 8)
            0:       dim_pick = 5'd16;
            1:       dim_pick = 5'd1;
            2:       dim_pick = 5'd0;
            3:       dim_pick = 5'd31;
            4:       dim_pick = 5'd17;
            5:       dim_pick = 5'($urandom_range(2, 15));
            6:       dim_pick = 5'($urandom_range(0, 31));
            default: dim_pick = 5'($urandom_range(1, 4));
         endcase
         case ($urandom_range(5))
            0:       alpha_pick = 32'h0000_0000;
            1:       alpha_pick = 32'h7FFF_FFFF;
            2:       alpha_pick = 32'h8000_0000;
            default: alpha_pick = $urandom;
         endcase
         write_reg(REG_DIM, {27'd0, dim_pick});
         write_reg(REG_ALPHA, alpha_pick);
         n = $urandom_range(50, 80);
         for (int i = 0; i < n; i++) begin
            // hold off the sender until all rates are back
            if (ph % 3 == 1 && i == n / 2)
               drain_rates();
            it.cmd   = ($urandom_range(99) < 88) ? CMD_ELEM : CMD_ENTRY;
            it.row   = POS_W'($urandom);
            it.col   = POS_W'($urandom);
            it.value = rand_q16();
            push_item(it, 1'b0, '0);
         end
      end

      // wind down
      drain_rates();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
